FILE: src/pbdc_pkg.sv
// Shared types and constants for the distance-constraint projection pipeline.
// Used by every module under src; no dependencies of its own.
package pbdc_pkg;

    // Pipeline depths of the iterative units
    localparam int SQRT_STEPS = 33;
    localparam int NDIV_STEPS = 17;
    localparam int SDIV_STEPS = 49;

    // Magnitude bound of a Q16.16 product, 2^62
    localparam logic [62:0] SAT_BOUND = 63'h4000_0000_0000_0000;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_STEP_GAIN = 2'd0,
        CFG_MIN_MASS  = 2'd1,
        CFG_NORM_BIAS = 2'd2
    } t_cfg_idx;

    // Everything one item carries down the pipeline; derived signed values are sign/magnitude
    typedef struct packed {
        logic [2:0][31:0] p1;
        logic [2:0][31:0] p2;
        logic [31:0]      w1;
        logic [31:0]      w2;
        logic [30:0]      rest;
        logic [32:0]      wt;
        logic [2:0]       dneg;
        logic [2:0][31:0] dmag;
        logic [2:0][63:0] sq;
        logic [65:0]      ssum;
        logic [32:0]      len;
        logic [33:0]      den;
        logic             den_zero;
        logic             cneg;
        logic [32:0]      cmag;
        logic [2:0]       nneg;
        logic [2:0][16:0] nmag;
        logic [2:0][33:0] nsqp;
        logic [19:0]      nsq;
        logic [36:0]      wsum;
        logic             sneg;
        logic [48:0]      smag;
        logic             moved;
        logic             gneg;
        logic [49:0]      gmag;
        logic [1:0][56:0] flo;
        logic [1:0][56:0] fhi;
        logic [1:0][62:0] fmag;
        logic [5:0]       uneg;
        logic [5:0][48:0] ulo;
        logic [5:0][47:0] uhi;
        logic [5:0][62:0] umag;
    } t_ctx;

endpackage

FILE: src/pbdc_sqrt.sv
// Pipelined integer square root of the 66-bit squared distance, one bit per stage.
// Depends on pbdc_pkg for the item context type.
module pbdc_sqrt (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  pbdc_pkg::t_ctx    i_ctx,
    output logic              o_valid,
    output pbdc_pkg::t_ctx    o_ctx
);

    logic           r_v    [pbdc_pkg::SQRT_STEPS];
    pbdc_pkg::t_ctx r_ctx  [pbdc_pkg::SQRT_STEPS];
    logic [35:0]    r_rem  [pbdc_pkg::SQRT_STEPS];
    logic [32:0]    r_root [pbdc_pkg::SQRT_STEPS];

    for (genvar j = 0; j < pbdc_pkg::SQRT_STEPS; j++) begin : g_step
        logic           v_in;
        pbdc_pkg::t_ctx ctx_in;
        logic [35:0]    rem_in;
        logic [32:0]    root_in;
        logic [37:0]    rem_s;
        logic [37:0]    trial;
        logic [35:0]    n_rem;
        logic [32:0]    n_root;

        if (j == 0) begin : g_first
            assign v_in    = i_valid;
            assign ctx_in  = i_ctx;
            assign rem_in  = '0;
            assign root_in = '0;
        end else begin : g_next
            assign v_in    = r_v[j-1];
            assign ctx_in  = r_ctx[j-1];
            assign rem_in  = r_rem[j-1];
            assign root_in = r_root[j-1];
        end

        // Bring down the next bit pair and try the trial subtrahend
        assign rem_s = {rem_in, ctx_in.ssum[2*(pbdc_pkg::SQRT_STEPS-1-j) +: 2]};
        assign trial = {3'b000, root_in, 2'b01};

        always_comb begin
            if (rem_s >= trial) begin
                n_rem  = 36'(rem_s - trial);
                n_root = {root_in[31:0], 1'b1};
            end else begin
                n_rem  = rem_s[35:0];
                n_root = {root_in[31:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (i_en) begin
                r_v[j] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ctx[j]  <= ctx_in;
                r_rem[j]  <= n_rem;
                r_root[j] <= n_root;
            end
        end
    end

    // Attach the root as the length
    always_comb begin
        o_ctx     = r_ctx[pbdc_pkg::SQRT_STEPS-1];
        o_ctx.len = r_root[pbdc_pkg::SQRT_STEPS-1];
    end
    assign o_valid = r_v[pbdc_pkg::SQRT_STEPS-1];

endmodule

FILE: src/pbdc_ndiv.sv
// Three-lane pipelined divider forming the unit direction |d|*2^16 / (L + bias).
// Depends on pbdc_pkg; the quotient never exceeds 2^16, so 17 stages suffice.
module pbdc_ndiv (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  pbdc_pkg::t_ctx    i_ctx,
    output logic              o_valid,
    output pbdc_pkg::t_ctx    o_ctx
);

    logic             r_v   [pbdc_pkg::NDIV_STEPS];
    pbdc_pkg::t_ctx   r_ctx [pbdc_pkg::NDIV_STEPS];
    logic [2:0][33:0] r_rem [pbdc_pkg::NDIV_STEPS];
    logic [2:0][16:0] r_q   [pbdc_pkg::NDIV_STEPS];

    for (genvar j = 0; j < pbdc_pkg::NDIV_STEPS; j++) begin : g_step
        logic             v_in;
        pbdc_pkg::t_ctx   ctx_in;
        logic [2:0][33:0] rem_in;
        logic [2:0][16:0] q_in;
        logic [2:0]       bit_in;
        logic [2:0][33:0] n_rem;
        logic [2:0][16:0] n_q;

        if (j == 0) begin : g_first
            // Top bits of the numerator start below the divisor
            assign v_in   = i_valid;
            assign ctx_in = i_ctx;
            assign q_in   = '0;
            for (genvar l = 0; l < 3; l++) begin : g_lane
                assign rem_in[l] = {3'b000, i_ctx.dmag[l][31:1]};
                assign bit_in[l] = i_ctx.dmag[l][0];
            end
        end else begin : g_next
            assign v_in   = r_v[j-1];
            assign ctx_in = r_ctx[j-1];
            assign rem_in = r_rem[j-1];
            assign q_in   = r_q[j-1];
            assign bit_in = '0;
        end

        // One restoring step per lane
        always_comb begin
            logic [34:0] rs;
            for (int l = 0; l < 3; l++) begin
                rs = {rem_in[l], bit_in[l]};
                if (rs >= {1'b0, ctx_in.den}) begin
                    n_rem[l] = 34'(rs - {1'b0, ctx_in.den});
                    n_q[l]   = {q_in[l][15:0], 1'b1};
                end else begin
                    n_rem[l] = rs[33:0];
                    n_q[l]   = {q_in[l][15:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (i_en) begin
                r_v[j] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ctx[j] <= ctx_in;
                r_rem[j] <= n_rem;
                r_q[j]   <= n_q;
            end
        end
    end

    // Zero divisor gives a zero direction
    always_comb begin
        o_ctx      = r_ctx[pbdc_pkg::NDIV_STEPS-1];
        o_ctx.nneg = o_ctx.dneg;
        for (int l = 0; l < 3; l++) begin
            o_ctx.nmag[l] = o_ctx.den_zero ? 17'd0 : r_q[pbdc_pkg::NDIV_STEPS-1][l];
        end
    end
    assign o_valid = r_v[pbdc_pkg::NDIV_STEPS-1];

endmodule

FILE: src/pbdc_sdiv.sv
// Pipelined divider forming the scale |C|*2^16 / wsum, one quotient bit per stage.
// Depends on pbdc_pkg for the item context type.
module pbdc_sdiv (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  pbdc_pkg::t_ctx    i_ctx,
    output logic              o_valid,
    output pbdc_pkg::t_ctx    o_ctx
);

    logic           r_v   [pbdc_pkg::SDIV_STEPS];
    pbdc_pkg::t_ctx r_ctx [pbdc_pkg::SDIV_STEPS];
    logic [36:0]    r_rem [pbdc_pkg::SDIV_STEPS];
    logic [48:0]    r_q   [pbdc_pkg::SDIV_STEPS];

    for (genvar j = 0; j < pbdc_pkg::SDIV_STEPS; j++) begin : g_step
        logic           v_in;
        pbdc_pkg::t_ctx ctx_in;
        logic [36:0]    rem_in;
        logic [48:0]    q_in;
        logic [48:0]    num;
        logic [37:0]    rs;
        logic [36:0]    n_rem;
        logic [48:0]    n_q;

        if (j == 0) begin : g_first
            assign v_in   = i_valid;
            assign ctx_in = i_ctx;
            assign rem_in = '0;
            assign q_in   = '0;
        end else begin : g_next
            assign v_in   = r_v[j-1];
            assign ctx_in = r_ctx[j-1];
            assign rem_in = r_rem[j-1];
            assign q_in   = r_q[j-1];
        end

        // Shift in the next numerator bit and subtract when it fits
        assign num = {ctx_in.cmag, 16'd0};
        assign rs  = {rem_in, num[pbdc_pkg::SDIV_STEPS-1-j]};

        always_comb begin
            if (rs >= {1'b0, ctx_in.wsum}) begin
                n_rem = 37'(rs - {1'b0, ctx_in.wsum});
                n_q   = {q_in[47:0], 1'b1};
            end else begin
                n_rem = rs[36:0];
                n_q   = {q_in[47:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (i_en) begin
                r_v[j] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ctx[j] <= ctx_in;
                r_rem[j] <= n_rem;
                r_q[j]   <= n_q;
            end
        end
    end

    // Quotient takes the sign of the constraint error
    always_comb begin
        o_ctx      = r_ctx[pbdc_pkg::SDIV_STEPS-1];
        o_ctx.sneg = o_ctx.cneg;
        o_ctx.smag = r_q[pbdc_pkg::SDIV_STEPS-1];
    end
    assign o_valid = r_v[pbdc_pkg::SDIV_STEPS-1];

endmodule

FILE: src/pbd_distance_constraint_project.sv
// Distance-constraint projection pipeline. Throughput one item per cycle while the
// output is not stalled; the 33-stage square root and the 17- and 49-stage dividers
// set the depth. An output stall freezes every stage, nothing is dropped.
// Reset clears all valid bits and loads step_gain=65536, min_mass_sum=1, norm_bias=1;
// the configuration port is always ready.
module pbd_distance_constraint_project (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Configuration writes
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [16:0]        i_cfg_data,
    // Input items
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [31:0] i_first_x,
    input  logic signed [31:0] i_first_y,
    input  logic signed [31:0] i_first_z,
    input  logic signed [31:0] i_second_x,
    input  logic signed [31:0] i_second_y,
    input  logic signed [31:0] i_second_z,
    input  logic [31:0]        i_first_inv_mass,
    input  logic [31:0]        i_second_inv_mass,
    input  logic [30:0]        i_rest_length,
    // Result items
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_new_first_x,
    output logic signed [31:0] o_new_first_y,
    output logic signed [31:0] o_new_first_z,
    output logic signed [31:0] o_new_second_x,
    output logic signed [31:0] o_new_second_y,
    output logic signed [31:0] o_new_second_z,
    output logic               o_moved,
    output logic               o_clipped
);

    logic [16:0] r_step_gain;
    logic [15:0] r_min_mass;
    logic [15:0] r_norm_bias;

    logic w_en;

    pbdc_pkg::t_ctx n_c1, n_c2, n_c3, n_c4, n_c5, n_c6, n_c7;
    pbdc_pkg::t_ctx n_c8, n_c9, n_c10, n_c11, n_c12;
    pbdc_pkg::t_ctx r_c1, r_c2, r_c3, r_c4, r_c5, r_c6, r_c7;
    pbdc_pkg::t_ctx r_c8, r_c9, r_c10, r_c11, r_c12;
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7;
    logic r_v8, r_v9, r_v10, r_v11, r_v12;

    logic           w_sqrt_v, w_ndiv_v, w_sdiv_v;
    pbdc_pkg::t_ctx w_sqrt_c, w_ndiv_c, w_sdiv_c;

    logic [5:0][31:0] n_new;
    logic             n_clipped;
    logic [5:0][31:0] r_new;
    logic             r_moved;
    logic             r_clipped;
    logic             r_out_v;

    // Advance the whole pipeline unless a finished item is held
    assign w_en       = !r_out_v || i_out_ready;
    assign o_in_ready = w_en;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_gain <= 17'd65536;
            r_min_mass  <= 16'd1;
            r_norm_bias <= 16'd1;
        end else if (i_cfg_valid) begin
            case (pbdc_pkg::t_cfg_idx'(i_cfg_index))
                pbdc_pkg::CFG_STEP_GAIN: r_step_gain <= i_cfg_data;
                pbdc_pkg::CFG_MIN_MASS:  r_min_mass  <= i_cfg_data[15:0];
                pbdc_pkg::CFG_NORM_BIAS: r_norm_bias <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Capture the item, form differences and the mass sum
    always_comb begin : s1_comb
        logic [32:0] diff;
        n_c1       = '0;
        n_c1.p1[0] = i_first_x;
        n_c1.p1[1] = i_first_y;
        n_c1.p1[2] = i_first_z;
        n_c1.p2[0] = i_second_x;
        n_c1.p2[1] = i_second_y;
        n_c1.p2[2] = i_second_z;
        n_c1.w1    = i_first_inv_mass;
        n_c1.w2    = i_second_inv_mass;
        n_c1.rest  = i_rest_length;
        n_c1.wt    = 33'(i_first_inv_mass) + 33'(i_second_inv_mass);
        for (int k = 0; k < 3; k++) begin
            diff = {n_c1.p1[k][31], n_c1.p1[k]} - {n_c1.p2[k][31], n_c1.p2[k]};
            n_c1.dneg[k] = diff[32];
            n_c1.dmag[k] = diff[32] ? 32'(-diff) : diff[31:0];
        end
    end

    // Square each difference
    always_comb begin : s2_comb
        n_c2 = r_c1;
        for (int k = 0; k < 3; k++) begin
            n_c2.sq[k] = 64'(r_c1.dmag[k]) * 64'(r_c1.dmag[k]);
        end
    end

    // Sum the squares
    always_comb begin : s3_comb
        n_c3      = r_c2;
        n_c3.ssum = 66'(r_c2.sq[0]) + 66'(r_c2.sq[1]) + 66'(r_c2.sq[2]);
    end

    pbdc_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v3),
        .i_ctx   (r_c3),
        .o_valid (w_sqrt_v),
        .o_ctx   (w_sqrt_c)
    );

    // Divisor and constraint error
    always_comb begin : s4_comb
        logic [33:0] c;
        n_c4          = w_sqrt_c;
        n_c4.den      = 34'(w_sqrt_c.len) + 34'(r_norm_bias);
        n_c4.den_zero = (n_c4.den == '0);
        c             = 34'(w_sqrt_c.len) - 34'(w_sqrt_c.rest);
        n_c4.cneg     = c[33];
        n_c4.cmag     = c[33] ? 33'(-c) : c[32:0];
    end

    pbdc_ndiv u_ndiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v4),
        .i_ctx   (r_c4),
        .o_valid (w_ndiv_v),
        .o_ctx   (w_ndiv_c)
    );

    // Square the direction components
    always_comb begin : s5_comb
        n_c5 = w_ndiv_c;
        for (int k = 0; k < 3; k++) begin
            n_c5.nsqp[k] = 34'(w_ndiv_c.nmag[k]) * 34'(w_ndiv_c.nmag[k]);
        end
    end

    // Sum and rescale the squared direction
    always_comb begin : s6_comb
        logic [35:0] sum;
        n_c6     = r_c5;
        sum      = 36'(r_c5.nsqp[0]) + 36'(r_c5.nsqp[1]) + 36'(r_c5.nsqp[2]);
        n_c6.nsq = sum[35:16];
    end

    // Weighted mass sum
    always_comb begin : s7_comb
        logic [52:0] prod;
        n_c7      = r_c6;
        prod      = 53'(r_c6.wt) * 53'(r_c6.nsq);
        n_c7.wsum = prod[52:16];
    end

    pbdc_sdiv u_sdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v7),
        .i_ctx   (r_c7),
        .o_valid (w_sdiv_v),
        .o_ctx   (w_sdiv_c)
    );

    // Apply the gain and decide whether the item moves
    always_comb begin : s8_comb
        logic [65:0] prod;
        n_c8       = w_sdiv_c;
        prod       = 66'(w_sdiv_c.smag) * 66'(r_step_gain);
        n_c8.gmag  = prod[65:16];
        n_c8.gneg  = w_sdiv_c.sneg;
        n_c8.moved = (w_sdiv_c.wt >= 33'(r_min_mass)) && (w_sdiv_c.wsum != '0) &&
                     (w_sdiv_c.wsum >= 37'(r_min_mass));
    end

    // Partial products of the gained scale with each inverse mass
    always_comb begin : s9_comb
        n_c9        = r_c8;
        n_c9.flo[0] = 57'(r_c8.gmag[24:0]) * 57'(r_c8.w1);
        n_c9.fhi[0] = 57'(r_c8.gmag[49:25]) * 57'(r_c8.w1);
        n_c9.flo[1] = 57'(r_c8.gmag[24:0]) * 57'(r_c8.w2);
        n_c9.fhi[1] = 57'(r_c8.gmag[49:25]) * 57'(r_c8.w2);
    end

    // Combine, rescale and bound the per-point factors
    always_comb begin : s10_comb
        logic [81:0] full;
        logic [65:0] sh;
        n_c10 = r_c9;
        for (int a = 0; a < 2; a++) begin
            full = {r_c9.fhi[a], 25'd0} + 82'(r_c9.flo[a]);
            sh   = full[81:16];
            n_c10.fmag[a] = (sh > 66'(pbdc_pkg::SAT_BOUND)) ? pbdc_pkg::SAT_BOUND : sh[62:0];
        end
    end

    // Partial products of each factor with each direction component
    always_comb begin : s11_comb
        n_c11 = r_c10;
        for (int a = 0; a < 2; a++) begin
            for (int k = 0; k < 3; k++) begin
                n_c11.ulo[3*a+k]  = 49'(r_c10.fmag[a][31:0]) * 49'(r_c10.nmag[k]);
                n_c11.uhi[3*a+k]  = 48'(r_c10.fmag[a][62:32]) * 48'(r_c10.nmag[k]);
                n_c11.uneg[3*a+k] = r_c10.gneg ^ r_c10.nneg[k];
            end
        end
    end

    // Combine, rescale and bound the coordinate corrections
    always_comb begin : s12_comb
        logic [79:0] full;
        logic [63:0] sh;
        n_c12 = r_c11;
        for (int i = 0; i < 6; i++) begin
            full = {r_c11.uhi[i], 32'd0} + 80'(r_c11.ulo[i]);
            sh   = full[79:16];
            n_c12.umag[i] = (sh > 64'(pbdc_pkg::SAT_BOUND)) ? pbdc_pkg::SAT_BOUND : sh[62:0];
        end
    end

    // Move the points, saturate, or pass them through
    always_comb begin : out_comb
        logic signed [64:0] base;
        logic signed [64:0] corr;
        logic signed [64:0] sum;
        n_new     = '0;
        n_clipped = 1'b0;
        for (int a = 0; a < 2; a++) begin
            for (int k = 0; k < 3; k++) begin
                base = (a == 0) ? 65'(signed'(r_c12.p1[k])) : 65'(signed'(r_c12.p2[k]));
                corr = {2'b00, r_c12.umag[3*a+k]};
                if ((a == 0) == r_c12.uneg[3*a+k]) begin
                    sum = base + corr;
                end else begin
                    sum = base - corr;
                end
                if (sum > 65'sd2147483647) begin
                    n_new[3*a+k] = 32'h7FFF_FFFF;
                    n_clipped    = 1'b1;
                end else if (sum < -65'sd2147483648) begin
                    n_new[3*a+k] = 32'h8000_0000;
                    n_clipped    = 1'b1;
                end else begin
                    n_new[3*a+k] = sum[31:0];
                end
            end
        end
        if (!r_c12.moved) begin
            for (int k = 0; k < 3; k++) begin
                n_new[k]   = r_c12.p1[k];
                n_new[3+k] = r_c12.p2[k];
            end
            n_clipped = 1'b0;
        end
    end

    // Valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_v4    <= 1'b0;
            r_v5    <= 1'b0;
            r_v6    <= 1'b0;
            r_v7    <= 1'b0;
            r_v8    <= 1'b0;
            r_v9    <= 1'b0;
            r_v10   <= 1'b0;
            r_v11   <= 1'b0;
            r_v12   <= 1'b0;
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_v1    <= i_in_valid;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_v4    <= w_sqrt_v;
            r_v5    <= w_ndiv_v;
            r_v6    <= r_v5;
            r_v7    <= r_v6;
            r_v8    <= w_sdiv_v;
            r_v9    <= r_v8;
            r_v10   <= r_v9;
            r_v11   <= r_v10;
            r_v12   <= r_v11;
            r_out_v <= r_v12;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c1      <= n_c1;
            r_c2      <= n_c2;
            r_c3      <= n_c3;
            r_c4      <= n_c4;
            r_c5      <= n_c5;
            r_c6      <= n_c6;
            r_c7      <= n_c7;
            r_c8      <= n_c8;
            r_c9      <= n_c9;
            r_c10     <= n_c10;
            r_c11     <= n_c11;
            r_c12     <= n_c12;
            r_new     <= n_new;
            r_moved   <= r_c12.moved;
            r_clipped <= n_clipped;
        end
    end

    assign o_out_valid    = r_out_v;
    assign o_new_first_x  = r_new[0];
    assign o_new_first_y  = r_new[1];
    assign o_new_first_z  = r_new[2];
    assign o_new_second_x = r_new[3];
    assign o_new_second_y = r_new[4];
    assign o_new_second_z = r_new[5];
    assign o_moved        = r_moved;
    assign o_clipped      = r_clipped;

`ifndef SYNTHESIS
    // A skipped item never reports saturation
    a_skip_no_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_moved |-> !o_clipped)
        else $error("clipped set on a pass-through item");

    // A held result blocks new items
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("item accepted while output stalled");

    // Reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");
`endif

endmodule
